// ===== hw/rtl/wtcc_pkg.sv =====
`default_nettype none

package wtcc_pkg;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_TORQUE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_TORQUE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FRICTION_TORQUE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WHEEL_SPEED = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_LIN_FRIC_RATIO  = 3'd4;

    localparam int FRAC_BITS  = 16;
    localparam int RATIO_BITS = 16;

    // where the wheel speed sits relative to the critical speed
    typedef enum logic [1:0] {
        RGN_ABOVE,
        RGN_BELOW,
        RGN_ZERO,
        RGN_LINEAR
    } t_region;

endpackage

`default_nettype wire

// ===== hw/rtl/wtcc_div_step.sv =====
`default_nettype none

// One step of the scaled divider: consumes one friction bit (MSB first) and keeps
// quo*d + rem == fr_prefix * a with rem < d. Since a <= d, 2*rem + a < 3*d, so at
// most two subtractions of d are needed.
module wtcc_div_step #(
    parameter int TORQUE_BITS = 24,
    parameter int SPEED_BITS  = 32
) (
    input  wire logic [SPEED_BITS-2:0]  i_rem,
    input  wire logic [TORQUE_BITS-2:0] i_quo,
    input  wire logic                   i_bit,
    input  wire logic [SPEED_BITS-2:0]  i_a,
    input  wire logic [SPEED_BITS-2:0]  i_d,
    output logic      [SPEED_BITS-2:0]  o_rem,
    output logic      [TORQUE_BITS-2:0] o_quo
);

    logic [SPEED_BITS:0] w_t;
    logic [SPEED_BITS:0] w_d1;
    logic [SPEED_BITS:0] w_d2;
    logic [SPEED_BITS:0] w_diff;
    logic [1:0]          w_k;

    always_comb begin
        w_d1 = {2'b00, i_d};
        w_d2 = {1'b0, i_d, 1'b0};
        w_t  = {1'b0, i_rem, 1'b0} + (i_bit ? {2'b00, i_a} : '0);
        if (w_t >= w_d2) begin
            w_diff = w_t - w_d2;
            w_k    = 2'd2;
        end else if (w_t >= w_d1) begin
            w_diff = w_t - w_d1;
            w_k    = 2'd1;
        end else begin
            w_diff = w_t;
            w_k    = 2'd0;
        end
        o_rem = w_diff[SPEED_BITS-2:0];
        o_quo = {i_quo[TORQUE_BITS-3:0], 1'b0} + (TORQUE_BITS-1)'(w_k);
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wheel_torque_command_conditioner.sv =====
// Wheel torque command conditioner, one wheel.
// Input stream: commanded torque and wheel speed in one transaction; output stream:
// applied torque after clipping to +/-max_torque (if nonzero), deadband, Coulomb
// friction (linear in speed below the critical speed) and saturation.
// Config channel: register index and data, always ready; write only while idle.
// The critical speed is registered from the config registers in the cycle after a write.
// Throughput: one transaction per cycle while the receiver does not stall. The friction
// divider resolves one friction bit per pipeline stage.
// Receiver stall: the whole pipeline holds and input tready drops; nothing is lost.
// Reset (synchronous, active low) clears all configuration registers to zero and
// empties the pipeline.
`default_nettype none

module wheel_torque_command_conditioner
    import wtcc_pkg::*;
#(
    parameter int TORQUE_BITS = 24,
    parameter int SPEED_BITS  = 32,
    localparam int IN_W  = ((TORQUE_BITS + SPEED_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((TORQUE_BITS + 7) / 8) * 8,
    localparam int CFG_W = (SPEED_BITS - 1 > TORQUE_BITS - 1) ?
                           ((SPEED_BITS - 1 > RATIO_BITS) ? SPEED_BITS - 1 : RATIO_BITS) :
                           ((TORQUE_BITS - 1 > RATIO_BITS) ? TORQUE_BITS - 1 : RATIO_BITS)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // commanded_torque, wheel_speed
    input  wire logic [IN_W-1:0]      i_s_axis_tdata,
    output logic                      o_m_axis_tvalid,
    input  wire logic                 i_m_axis_tready,
    // applied_torque
    output logic      [OUT_W-1:0]     o_m_axis_tdata,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    localparam int TB    = TORQUE_BITS;
    localparam int SB    = SPEED_BITS;
    localparam int NSTEP = TB - 1;

    typedef struct packed {
        logic signed [TB-1:0] cmd;
        t_region              region;
        logic                 neg;
        logic [SB-2:0]        a;
        logic [SB-2:0]        rem;
        logic [TB-2:0]        quo;
    } t_div_item;

    // configuration
    logic [TB-2:0]         r_max_torque;
    logic [TB-2:0]         r_min_torque;
    logic [TB-2:0]         r_fric;
    logic [SB-2:0]         r_max_speed;
    logic [RATIO_BITS-1:0] r_ratio;
    logic [SB-2:0]         r_omega_c;
    logic [SB+RATIO_BITS-2:0] w_omega_prod;

    // pipeline
    logic                 w_adv;
    logic                 r_v0;
    logic                 r_v1;
    logic [NSTEP:0]       r_vdiv;
    logic                 r_out_vld;
    logic signed [TB-1:0] r_s0_cmd;
    logic signed [SB-1:0] r_s0_spd;
    logic signed [TB-1:0] r_s1_cmd;
    logic signed [SB-1:0] r_s1_spd;
    t_div_item            r_div [NSTEP+1];
    t_div_item            n_div [NSTEP+1];
    logic [SB-2:0]        w_step_rem [NSTEP];
    logic [TB-2:0]        w_step_quo [NSTEP];
    logic signed [TB-1:0] r_out_data;
    logic signed [TB-1:0] n_out_data;

    logic signed [TB-1:0] n_s1_cmd;
    logic signed [TB-1:0] w_lim;
    logic [TB-1:0]        w_mag;
    logic signed [SB:0]   w_spd_ext;
    logic signed [SB:0]   w_om_ext;
    logic [SB-1:0]        w_abs_spd;
    logic signed [TB:0]   w_c;
    logic signed [TB:0]   w_f;
    logic signed [TB:0]   w_q;
    logic signed [TB:0]   w_u;

    assign o_cfg_ready     = 1'b1;
    assign w_adv           = !r_out_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {{(OUT_W-TB){1'b0}}, r_out_data};

    assign w_omega_prod = r_max_speed * r_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_torque <= '0;
            r_min_torque <= '0;
            r_fric       <= '0;
            r_max_speed  <= '0;
            r_ratio      <= '0;
            r_omega_c    <= '0;
        end else begin
            r_omega_c <= w_omega_prod[SB+RATIO_BITS-2:FRAC_BITS];
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_MAX_TORQUE:      r_max_torque <= i_cfg_data[TB-2:0];
                    CFG_MIN_TORQUE:      r_min_torque <= i_cfg_data[TB-2:0];
                    CFG_FRICTION_TORQUE: r_fric       <= i_cfg_data[TB-2:0];
                    CFG_MAX_WHEEL_SPEED: r_max_speed  <= i_cfg_data[SB-2:0];
                    CFG_LIN_FRIC_RATIO:  r_ratio      <= i_cfg_data[RATIO_BITS-1:0];
                    default: ;
                endcase
            end
        end
    end

    // stage 1: clip
    always_comb begin
        w_lim    = $signed({1'b0, r_max_torque});
        n_s1_cmd = r_s0_cmd;
        if (r_max_torque != '0) begin
            if (r_s0_cmd > w_lim) begin
                n_s1_cmd = w_lim;
            end else if (r_s0_cmd < -w_lim) begin
                n_s1_cmd = -w_lim;
            end
        end
    end

    // stage 2: deadband, speed region, divider seed; divider stages carry their item
    always_comb begin
        w_mag     = r_s1_cmd[TB-1] ? TB'(-r_s1_cmd) : TB'(r_s1_cmd);
        w_spd_ext = (SB+1)'(r_s1_spd);
        w_om_ext  = $signed({2'b00, r_omega_c});
        w_abs_spd = r_s1_spd[SB-1] ? SB'(-r_s1_spd) : SB'(r_s1_spd);

        n_div[0].cmd = (w_mag < {1'b0, r_min_torque}) ? '0 : r_s1_cmd;
        n_div[0].neg = r_s1_spd[SB-1];
        n_div[0].a   = w_abs_spd[SB-2:0];
        n_div[0].rem = '0;
        n_div[0].quo = '0;
        if (w_spd_ext > w_om_ext) begin
            n_div[0].region = RGN_ABOVE;
        end else if (w_spd_ext < -w_om_ext) begin
            n_div[0].region = RGN_BELOW;
        end else if (r_omega_c == '0) begin
            n_div[0].region = RGN_ZERO;
        end else begin
            n_div[0].region = RGN_LINEAR;
        end

        for (int k = 0; k < NSTEP; k++) begin
            n_div[k+1]     = r_div[k];
            n_div[k+1].rem = w_step_rem[k];
            n_div[k+1].quo = w_step_quo[k];
        end
    end

    // divider: floor(fr * |speed| / omega_c), one friction bit per stage
    for (genvar i = 0; i < NSTEP; i++) begin : g_div
        wtcc_div_step #(
            .TORQUE_BITS (TORQUE_BITS),
            .SPEED_BITS  (SPEED_BITS)
        ) u_step (
            .i_rem (r_div[i].rem),
            .i_quo (r_div[i].quo),
            .i_bit (r_fric[NSTEP-1-i]),
            .i_a   (r_div[i].a),
            .i_d   (r_omega_c),
            .o_rem (w_step_rem[i]),
            .o_quo (w_step_quo[i])
        );
    end

    // final: apply friction and saturate
    always_comb begin
        w_c = (TB+1)'(r_div[NSTEP].cmd);
        w_f = $signed({2'b00, r_fric});
        w_q = $signed({2'b00, r_div[NSTEP].quo});
        case (r_div[NSTEP].region)
            RGN_ABOVE:  w_u = w_c - w_f;
            RGN_BELOW:  w_u = w_c + w_f;
            RGN_LINEAR: w_u = r_div[NSTEP].neg ? w_c + w_q : w_c - w_q;
            default:    w_u = w_c;
        endcase
        if (w_u[TB] != w_u[TB-1]) begin
            n_out_data = w_u[TB] ? {1'b1, {(TB-1){1'b0}}} : {1'b0, {(TB-1){1'b1}}};
        end else begin
            n_out_data = w_u[TB-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0      <= 1'b0;
            r_v1      <= 1'b0;
            r_vdiv    <= '0;
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_v0      <= i_s_axis_tvalid;
            r_v1      <= r_v0;
            r_vdiv    <= {r_vdiv[NSTEP-1:0], r_v1};
            r_out_vld <= r_vdiv[NSTEP];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_cmd   <= i_s_axis_tdata[TB-1:0];
            r_s0_spd   <= i_s_axis_tdata[TB+SB-1:TB];
            r_s1_cmd   <= n_s1_cmd;
            r_s1_spd   <= r_s0_spd;
            r_div      <= n_div;
            r_out_data <= n_out_data;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/wtcc_checker.sv =====
`default_nettype none

module wtcc_checker
    import wtcc_pkg::*;
#(
    parameter int TORQUE_BITS = 24,
    parameter int SPEED_BITS  = 32,
    localparam int IN_W  = ((TORQUE_BITS + SPEED_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((TORQUE_BITS + 7) / 8) * 8,
    localparam int CFG_W = (SPEED_BITS - 1 > TORQUE_BITS - 1) ?
                           ((SPEED_BITS - 1 > RATIO_BITS) ? SPEED_BITS - 1 : RATIO_BITS) :
                           ((TORQUE_BITS - 1 > RATIO_BITS) ? TORQUE_BITS - 1 : RATIO_BITS)
) (
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_s_axis_tvalid,
    input wire logic                 o_s_axis_tready,
    input wire logic [IN_W-1:0]      i_s_axis_tdata,
    input wire logic                 o_m_axis_tvalid,
    input wire logic                 i_m_axis_tready,
    input wire logic [OUT_W-1:0]     o_m_axis_tdata,
    input wire logic                 i_cfg_valid,
    input wire logic                 o_cfg_ready,
    input wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input wire logic [CFG_W-1:0]     i_cfg_data
);

    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output transaction changed while stalled");

    // a stall at the output freezes the whole pipe, so no new transaction enters
    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input accepted while output stalled");

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    // with nothing stalled at the output, the input is always open
    a_ready_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_axis_tvalid |-> o_s_axis_tready && o_cfg_ready)
        else $error("input blocked while output empty");

endmodule

bind wheel_torque_command_conditioner wtcc_checker #(
    .TORQUE_BITS (TORQUE_BITS),
    .SPEED_BITS  (SPEED_BITS)
) u_wtcc_checker (.*);

`default_nettype wire

// ===== test/wtcc_checker.sv =====
module wtcc_scoreboard
    import wtcc_pkg::*;
#(
    parameter int TORQUE_BITS = 24,
    parameter int SPEED_BITS  = 32,
    localparam int IN_W  = ((TORQUE_BITS + SPEED_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((TORQUE_BITS + 7) / 8) * 8,
    localparam int CFG_W = (SPEED_BITS - 1 > TORQUE_BITS - 1) ?
                           ((SPEED_BITS - 1 > RATIO_BITS) ? SPEED_BITS - 1 : RATIO_BITS) :
                           ((TORQUE_BITS - 1 > RATIO_BITS) ? TORQUE_BITS - 1 : RATIO_BITS)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_s_tvalid,
    input  wire logic                 i_s_tready,
    // commanded_torque, wheel_speed
    input  wire logic [IN_W-1:0]      i_s_tdata,
    input  wire logic                 i_m_tvalid,
    input  wire logic                 i_m_tready,
    // applied_torque
    input  wire logic [OUT_W-1:0]     i_m_tdata,
    input  wire logic                 i_cfg_valid,
    input  wire logic                 i_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [TORQUE_BITS-1:0] t_torque;
    typedef logic signed [SPEED_BITS-1:0]  t_speed;

    logic [TORQUE_BITS-2:0] max_torque;
    logic [TORQUE_BITS-2:0] min_torque;
    logic [TORQUE_BITS-2:0] friction_torque;
    logic [SPEED_BITS-2:0]  max_wheel_speed;
    logic [RATIO_BITS-1:0]  friction_ratio;
    t_torque                applied_q[$];
    int                     fail_count;

    // clip, deadband, Coulomb friction against speed, then saturate
    function automatic t_torque conditioned_torque(t_torque command, t_speed speed);
        longint          cmd;
        longint          spd;
        longint          lim;
        longint          fric;
        longint          omega_c;
        longint          u;
        longint          term;
        longint          tmax;
        longint          tmin;
        longint unsigned aspeed;
        cmd  = command;
        spd  = speed;
        lim  = longint'(max_torque);
        fric = longint'(friction_torque);
        tmax = (longint'(1) <<< (TORQUE_BITS - 1)) - 1;
        tmin = -tmax - 1;
        if (lim > 0) begin
            if (cmd > lim)
                cmd = lim;
            else if (cmd < -lim)
                cmd = -lim;
        end
        if ((cmd < 0 ? -cmd : cmd) < longint'(min_torque))
            cmd = 0;
        omega_c = longint'((64'(max_wheel_speed) * 64'(friction_ratio)) >> FRAC_BITS);
        if (spd > omega_c) begin
            u = cmd - fric;
        end else if (spd < -omega_c) begin
            u = cmd + fric;
        end else if (omega_c == 0) begin
            u = cmd;
        end else begin
            // |speed| <= omega_c here, so the quotient never exceeds the friction torque
            aspeed = (spd < 0) ? -spd : spd;
            term   = longint'((64'(friction_torque) * aspeed) / 64'(omega_c));
            u      = (spd < 0) ? cmd + term : cmd - term;
        end
        if (u > tmax)
            u = tmax;
        if (u < tmin)
            u = tmin;
        return t_torque'(u[TORQUE_BITS-1:0]);
    endfunction

    always @(posedge i_clk) begin
        t_torque expected;
        t_torque actual;
        if (!i_rst_n) begin
            max_torque      = '0;
            min_torque      = '0;
            friction_torque = '0;
            max_wheel_speed = '0;
            friction_ratio  = '0;
            applied_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MAX_TORQUE:      max_torque      = i_cfg_data[TORQUE_BITS-2:0];
                    CFG_MIN_TORQUE:      min_torque      = i_cfg_data[TORQUE_BITS-2:0];
                    CFG_FRICTION_TORQUE: friction_torque = i_cfg_data[TORQUE_BITS-2:0];
                    CFG_MAX_WHEEL_SPEED: max_wheel_speed = i_cfg_data[SPEED_BITS-2:0];
                    CFG_LIN_FRIC_RATIO:  friction_ratio  = i_cfg_data[RATIO_BITS-1:0];
                    default: ;
                endcase
            end
            if (i_s_tvalid && i_s_tready)
                applied_q.insert(applied_q.size(), conditioned_torque(
                    t_torque'(i_s_tdata[TORQUE_BITS-1:0]),
                    t_speed'(i_s_tdata[TORQUE_BITS +: SPEED_BITS])));
            if (i_m_tvalid && i_m_tready) begin
                actual = t_torque'(i_m_tdata[TORQUE_BITS-1:0]);
                if (applied_q.size() == 0) begin
                    $error("applied_torque: no transaction expected, actual %0d", actual);
                    fail_count++;
                end else begin
                    expected = applied_q.pop_front();
                    if (actual !== expected) begin
                        $error("applied_torque mismatch: expected %0d, actual %0d",
                               expected, actual);
                        fail_count++;
                    end
                end
            end
        end
        o_pending    <= applied_q.size();
        o_fail_count <= fail_count;
    end

endmodule

// ===== test/wheel_torque_command_conditioner_tb.sv =====
module wheel_torque_command_conditioner_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wtcc_pkg::*;

    localparam int TORQUE_BITS = 24;
    localparam int SPEED_BITS  = 32;
    localparam int IN_W  = ((TORQUE_BITS + SPEED_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((TORQUE_BITS + 7) / 8) * 8;
    localparam int CFG_W = (SPEED_BITS - 1 > TORQUE_BITS - 1) ?
                           ((SPEED_BITS - 1 > RATIO_BITS) ? SPEED_BITS - 1 : RATIO_BITS) :
                           ((TORQUE_BITS - 1 > RATIO_BITS) ? TORQUE_BITS - 1 : RATIO_BITS);
    localparam int LATENCY         = TORQUE_BITS + 2;
    localparam int STALL_LIMIT     = 5000;
    localparam int HOLD_CYCLES     = 300;
    localparam int RANDOM_PHASES   = 9;
    localparam int ITEMS_PER_PHASE = 145;

    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    localparam longint TORQUE_HI = (longint'(1) <<< (TORQUE_BITS - 1)) - 1;
    localparam longint TORQUE_LO = -TORQUE_HI - 1;
    localparam longint SPEED_HI  = (longint'(1) <<< (SPEED_BITS - 1)) - 1;
    localparam longint SPEED_LO  = -SPEED_HI - 1;
    localparam longint TREG_MAX  = TORQUE_HI;
    localparam longint SREG_MAX  = SPEED_HI;
    localparam longint RATIO_MAX = (longint'(1) <<< RATIO_BITS) - 1;

    typedef enum logic [1:0] {
        PACE_RX_SLOW,
        PACE_TX_SLOW,
        PACE_FULL
    } t_pace;

    logic               i_clk       = 1'b0;
    logic               i_rst_n     = 1'b0;
    logic               s_tvalid    = 1'b0;
    logic [IN_W-1:0]    s_tdata     = '0;
    logic               m_tready    = 1'b0;
    logic               cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]   cfg_data    = '0;
    wire logic          s_tready;
    wire logic          m_tvalid;
    wire logic [OUT_W-1:0] m_tdata;
    wire logic          cfg_ready;
    int                 fail_count;
    int                 pending;

    t_pace  pace      = PACE_RX_SLOW;
    longint cur_lim   = 0;
    longint cur_min   = 0;
    longint cur_omega = 0;

    always #5 i_clk = ~i_clk;

    wheel_torque_command_conditioner #(
        .TORQUE_BITS (TORQUE_BITS),
        .SPEED_BITS  (SPEED_BITS)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_index     (cfg_index),
        .i_cfg_data      (cfg_data)
    );

    wtcc_scoreboard #(
        .TORQUE_BITS (TORQUE_BITS),
        .SPEED_BITS  (SPEED_BITS)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    function automatic int tx_idle_pct(t_pace p);
        case (p)
            PACE_RX_SLOW: return 31;
            PACE_TX_SLOW: return 80;
            default:      return 0;
        endcase
    endfunction

    function automatic int rx_idle_pct(t_pace p);
        case (p)
            PACE_RX_SLOW: return 80;
            PACE_TX_SLOW: return 31;
            default:      return 0;
        endcase
    endfunction

    // receiver pacing; entering full rate starts one long hold-off so the pipe backs up
    initial begin : rx_pacing
        int    hold_left;
        t_pace last_pace;
        hold_left = 0;
        last_pace = PACE_RX_SLOW;
        forever begin
            @(posedge i_clk);
            if (pace == PACE_FULL && last_pace != PACE_FULL)
                hold_left = HOLD_CYCLES;
            last_pace = pace;
            if (hold_left > 0) begin
                m_tready <= 1'b0;
                hold_left--;
            end else begin
                m_tready <= ($urandom_range(99) >= rx_idle_pct(pace));
            end
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("wheel_torque_command_conditioner regression: fail");
        $finish;
    end

    // leaves cfg_valid high; the caller drops it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic apply_config(input longint lim, input longint mn, input longint fric,
                                input longint mws, input longint ratio);
        longint mws_m;
        longint ratio_m;
        drain();
        write_reg(CFG_MAX_TORQUE, CFG_W'(lim));
        write_reg(CFG_MIN_TORQUE, CFG_W'(mn));
        write_reg(CFG_FRICTION_TORQUE, CFG_W'(fric));
        write_reg(CFG_MAX_WHEEL_SPEED, CFG_W'(mws));
        write_reg(CFG_LIN_FRIC_RATIO, CFG_W'(ratio));
        write_reg(CFG_UNMAPPED, CFG_W'($urandom));
        cfg_valid <= 1'b0;
        // critical speed register settles in the cycle after the last write
        @(posedge i_clk);
        cur_lim   = lim & TREG_MAX;
        cur_min   = mn & TREG_MAX;
        mws_m     = mws & SREG_MAX;
        ratio_m   = ratio & RATIO_MAX;
        cur_omega = (mws_m * ratio_m) >>> FRAC_BITS;
    endtask

    task automatic send_torque_cmd(input longint cmd, input longint spd);
        if ($urandom_range(99) < tx_idle_pct(pace)) begin
            s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < tx_idle_pct(pace));
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'({spd[SPEED_BITS-1:0], cmd[TORQUE_BITS-1:0]});
        do @(posedge i_clk); while (!s_tready);
    endtask

    function automatic longint random_sign(input longint v);
        return $urandom_range(1) ? -v : v;
    endfunction

    function automatic longint pick_command();
        case ($urandom_range(9))
            0:       return TORQUE_HI;
            1:       return TORQUE_LO;
            2, 3:    return random_sign(cur_lim + int'($urandom_range(8)) - 4);
            4, 5:    return random_sign(cur_min + int'($urandom_range(8)) - 4);
            6:       return random_sign(longint'($urandom_range(4096)));
            default: return longint'($urandom);
        endcase
    endfunction

    function automatic longint pick_speed();
        case ($urandom_range(19))
            0:       return SPEED_HI;
            1:       return SPEED_LO;
            2:       return 0;
            3, 4, 5: return random_sign(cur_omega + int'($urandom_range(4)) - 2);
            6, 7, 8, 9, 10, 11, 12, 13: begin
                if (cur_omega == 0)
                    return random_sign(longint'($urandom_range(1)));
                return random_sign(longint'($urandom_range(32'(cur_omega))));
            end
            default: return longint'($urandom);
        endcase
    endfunction

    function automatic longint pick_reg(input longint reg_max);
        case ($urandom_range(6))
            0:       return 0;
            1:       return reg_max;
            2, 3:    return longint'($urandom_range(32'hFFFF));
            4:       return longint'($urandom) & ((longint'(1) <<< CFG_W) - 1);
            default: return longint'($urandom) & reg_max;
        endcase
    endfunction

    initial begin : stimulus
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // registers at reset: no clipping, no deadband, no friction
        send_torque_cmd(TORQUE_HI, SPEED_HI);
        send_torque_cmd(TORQUE_LO, SPEED_LO);
        send_torque_cmd(0, 0);
        send_torque_cmd(TORQUE_HI, SPEED_LO);

        // clipping, deadband edge, above, below and linear friction regions incl. the band edges
        apply_config('h100000, 'h8000, 'h4000, 'h100000, 'h8000);
        send_torque_cmd('h180000, 'h100000);
        send_torque_cmd(-'h180000, -'h100000);
        send_torque_cmd('h7FFF, 'h100000);
        send_torque_cmd(-'h7FFF, 0);
        send_torque_cmd('h8000, 'h40000);
        send_torque_cmd(-'h8000, -'h40000);
        send_torque_cmd('h20000, 'h80000);
        send_torque_cmd('h20000, -'h80000);
        send_torque_cmd('h20000, 'h80001);
        send_torque_cmd('h20000, -'h80001);

        // full friction drives the sum out of range both ways
        apply_config(0, 0, TREG_MAX, SREG_MAX, 1);
        send_torque_cmd(TORQUE_HI, SPEED_LO);
        send_torque_cmd(TORQUE_LO, SPEED_HI);
        send_torque_cmd(0, 1);
        send_torque_cmd('h1234, -'h7FFF);

        // ratio nonzero but critical speed truncates to zero
        apply_config(TREG_MAX, TREG_MAX, 'h10, 1, 1);
        send_torque_cmd(TORQUE_LO, 0);
        send_torque_cmd(TORQUE_HI, 1);
        send_torque_cmd('h7FFFFE, -1);

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            apply_config(pick_reg(TREG_MAX), pick_reg(TREG_MAX), pick_reg(TREG_MAX),
                         pick_reg(SREG_MAX), pick_reg(RATIO_MAX));
            pace = t_pace'(ph % 3);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_torque_cmd(pick_command(), pick_speed());
        end

        drain();
        if (fail_count == 0)
            $display("wheel_torque_command_conditioner regression: pass");
        else
            $display("wheel_torque_command_conditioner regression: fail");
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/wtcc_pkg.sv
hw/rtl/wtcc_div_step.sv
hw/rtl/wheel_torque_command_conditioner.sv
hw/rtl/wtcc_checker.sv
test/wtcc_checker.sv
test/wheel_torque_command_conditioner_tb.sv
